FILE: sv/gfm_pkg.sv
package gfm_pkg;

  localparam int MAP_SLOTS_DEF     = 4;
  localparam int CELLS_PER_MAP_DEF = 4096;
  localparam int CELL_W            = 16;
  localparam int DIM_W             = 11;
  localparam int PROD_W            = 2 * DIM_W;
  localparam logic [CELL_W-1:0] FLAG_LIMIT_RESET = 16'hFFFF;

  typedef enum logic [3:0] {
    OP_NEW_MAP    = 4'd0,
    OP_FREE_MAP   = 4'd1,
    OP_FREE_ALL   = 4'd2,
    OP_SET        = 4'd3,
    OP_CLEAR      = 4'd4,
    OP_TEST       = 4'd5,
    OP_READ       = 4'd6,
    OP_CLEAR_MAP  = 4'd7,
    OP_FILL_MAP   = 4'd8,
    OP_CELL_VALID = 4'd9
  } gfm_op_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_NO_MAP    = 3'd1,
    STS_BAD_FLAG  = 3'd2,
    STS_BOUNDS    = 3'd3,
    STS_NO_SLOT   = 3'd4,
    STS_TOO_LARGE = 3'd5
  } gfm_status_t;

  typedef struct packed {
    logic [3:0]       op;
    logic [1:0]       map_index;
    logic [9:0]       x_coord;
    logic [9:0]       y_coord;
    logic [15:0]      flag_bits;
    logic [DIM_W-1:0] map_width;
    logic [DIM_W-1:0] map_height;
  } gfm_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] result_value;
  } gfm_rsp_t;

endpackage

FILE: sv/gfm_cell_mem.sv
module gfm_cell_mem #(
  parameter int DEPTH  = gfm_pkg::MAP_SLOTS_DEF * gfm_pkg::CELLS_PER_MAP_DEF,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int DATA_W = gfm_pkg::CELL_W
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/gfm_ctrl.sv
module gfm_ctrl #(
  parameter int MAP_SLOTS     = gfm_pkg::MAP_SLOTS_DEF,
  parameter int CELLS_PER_MAP = gfm_pkg::CELLS_PER_MAP_DEF,
  parameter int ADDR_W        = $clog2(MAP_SLOTS * CELLS_PER_MAP)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  gfm_pkg::gfm_req_t         req,
  input  logic [gfm_pkg::CELL_W-1:0] flag_mask_limit,
  output logic                      done,
  output gfm_pkg::gfm_rsp_t         rsp,
  output logic                      wr_en,
  output logic [ADDR_W-1:0]         wr_addr,
  output logic [gfm_pkg::CELL_W-1:0] wr_data,
  output logic                      rd_en,
  output logic [ADDR_W-1:0]         rd_addr,
  input  logic [gfm_pkg::CELL_W-1:0] rd_data
);

  import gfm_pkg::*;

  localparam int SLOT_W = (MAP_SLOTS > 1) ? $clog2(MAP_SLOTS) : 1;
  localparam int CNT_W  = $clog2(CELLS_PER_MAP + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_SIZE  = 6'b000100,
    S_ADDR  = 6'b001000,
    S_MOD   = 6'b010000,
    S_WALK  = 6'b100000
  } state_t;

  state_t             state;
  gfm_req_t           req_r;
  logic               in_use [MAP_SLOTS];
  logic [DIM_W-1:0]   slot_w [MAP_SLOTS];
  logic [DIM_W-1:0]   slot_h [MAP_SLOTS];
  logic [PROD_W-1:0]  prod;
  logic [ADDR_W-1:0]  base;
  logic [ADDR_W-1:0]  cell_addr;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   n_cells;
  logic               pend;
  logic [ADDR_W-1:0]  pend_addr;
  logic [SLOT_W-1:0]  new_slot;

  logic [SLOT_W-1:0]  s;
  logic               slot_ok;
  logic               have;
  logic [DIM_W-1:0]   cur_w;
  logic [DIM_W-1:0]   cur_h;
  logic               in_map;
  logic               bad_flag;
  logic               free_found;
  logic [SLOT_W-1:0]  free_idx;
  logic [DIM_W-1:0]   mul_a;
  logic [DIM_W-1:0]   mul_b;
  logic [SLOT_W-1:0]  base_slot;
  logic [ADDR_W-1:0]  addr_calc;
  logic [ADDR_W-1:0]  walk_addr;
  logic               walk_rmw;
  logic               walk_more;
  logic               walk_rd;
  logic               walk_end;
  logic               set_like;
  logic               is_new;

  assign s        = SLOT_W'(req_r.map_index);
  assign slot_ok  = 32'(req_r.map_index) < MAP_SLOTS;
  assign have     = slot_ok && in_use[s];
  assign cur_w    = slot_w[s];
  assign cur_h    = slot_h[s];
  assign in_map   = (DIM_W'(req_r.x_coord) < cur_w) && (DIM_W'(req_r.y_coord) < cur_h);
  assign bad_flag = req_r.flag_bits > flag_mask_limit;
  assign is_new   = req_r.op == OP_NEW_MAP;

  // lowest free slot wins
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAP_SLOTS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // one shared multiplier: map size for allocate/sweep, row offset for cell ops
  always_comb begin
    if (is_new) begin
      mul_a = req_r.map_width;
      mul_b = req_r.map_height;
    end else if (req_r.op == OP_SET || req_r.op == OP_CLEAR ||
                 req_r.op == OP_TEST || req_r.op == OP_READ) begin
      mul_a = DIM_W'(req_r.y_coord);
      mul_b = cur_w;
    end else begin
      mul_a = cur_w;
      mul_b = cur_h;
    end
  end

  assign base_slot = is_new ? free_idx : s;
  assign addr_calc = base + ADDR_W'(req_r.x_coord) + ADDR_W'(prod);
  assign walk_addr = base + ADDR_W'(cnt);
  assign walk_rmw  = (req_r.op == OP_CLEAR_MAP) || (req_r.op == OP_FILL_MAP);
  assign walk_more = cnt != n_cells;
  assign walk_rd   = walk_more && walk_rmw;
  assign walk_end  = !walk_more && !pend;
  assign set_like  = (req_r.op == OP_SET) || (req_r.op == OP_FILL_MAP);

  assign busy = state != S_IDLE;

  // sweep reads entry i while writing back entry i-1, so the ports never collide
  always_comb begin
    rd_en   = (state == S_ADDR) || (state == S_WALK && walk_rd);
    rd_addr = (state == S_ADDR) ? addr_calc : walk_addr;
    wr_en   = (state == S_MOD && (req_r.op == OP_SET || req_r.op == OP_CLEAR)) ||
              (state == S_WALK && (pend || (is_new && walk_more)));
    if (state == S_MOD) begin
      wr_addr = cell_addr;
    end else if (is_new) begin
      wr_addr = walk_addr;
    end else begin
      wr_addr = pend_addr;
    end
    if (is_new) begin
      wr_data = '0;
    end else if (set_like) begin
      wr_data = rd_data | req_r.flag_bits;
    end else begin
      wr_data = rd_data & ~req_r.flag_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      pend  <= 1'b0;
      for (int i = 0; i < MAP_SLOTS; i++) begin
        in_use[i] <= 1'b0;
        slot_w[i] <= '0;
        slot_h[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req_r <= req;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          prod     <= mul_a * mul_b;
          base     <= ADDR_W'(32'(base_slot) * CELLS_PER_MAP);
          new_slot <= free_idx;
          cnt      <= '0;
          pend     <= 1'b0;
          rsp.result_value <= '0;
          case (req_r.op)
            OP_NEW_MAP: begin
              if (!free_found) begin
                rsp.status <= STS_NO_SLOT;
                done       <= 1'b1;
                state      <= S_IDLE;
              end else begin
                state <= S_SIZE;
              end
            end
            OP_FREE_MAP: begin
              if (!have) begin
                rsp.status <= STS_NO_MAP;
              end else begin
                rsp.status <= STS_OK;
                in_use[s]  <= 1'b0;
                slot_w[s]  <= '0;
                slot_h[s]  <= '0;
              end
              done  <= 1'b1;
              state <= S_IDLE;
            end
            OP_FREE_ALL: begin
              for (int i = 0; i < MAP_SLOTS; i++) begin
                in_use[i] <= 1'b0;
                slot_w[i] <= '0;
                slot_h[i] <= '0;
              end
              rsp.status <= STS_OK;
              done       <= 1'b1;
              state      <= S_IDLE;
            end
            OP_SET, OP_CLEAR, OP_TEST, OP_READ: begin
              if (!have) begin
                rsp.status <= STS_NO_MAP;
                done       <= 1'b1;
                state      <= S_IDLE;
              end else if (req_r.op != OP_READ && bad_flag) begin
                rsp.status <= STS_BAD_FLAG;
                done       <= 1'b1;
                state      <= S_IDLE;
              end else if (!in_map) begin
                rsp.status <= STS_BOUNDS;
                done       <= 1'b1;
                state      <= S_IDLE;
              end else begin
                state <= S_ADDR;
              end
            end
            OP_CLEAR_MAP, OP_FILL_MAP: begin
              if (!have) begin
                rsp.status <= STS_NO_MAP;
                done       <= 1'b1;
                state      <= S_IDLE;
              end else if (bad_flag) begin
                rsp.status <= STS_BAD_FLAG;
                done       <= 1'b1;
                state      <= S_IDLE;
              end else begin
                state <= S_SIZE;
              end
            end
            OP_CELL_VALID: begin
              rsp.status       <= STS_OK;
              rsp.result_value <= 16'(have && in_map);
              done             <= 1'b1;
              state            <= S_IDLE;
            end
            default: begin
              rsp.status <= STS_OK;
              done       <= 1'b1;
              state      <= S_IDLE;
            end
          endcase
        end
        S_SIZE: begin
          if (is_new && 32'(prod) > CELLS_PER_MAP) begin
            rsp.status <= STS_TOO_LARGE;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else begin
            if (is_new) begin
              in_use[new_slot] <= 1'b1;
              slot_w[new_slot] <= req_r.map_width;
              slot_h[new_slot] <= req_r.map_height;
            end
            n_cells <= CNT_W'(prod);
            state   <= S_WALK;
          end
        end
        S_ADDR: begin
          cell_addr <= addr_calc;
          state     <= S_MOD;
        end
        S_MOD: begin
          rsp.status <= STS_OK;
          if (req_r.op == OP_TEST) begin
            rsp.result_value <= 16'(|(rd_data & req_r.flag_bits));
          end else if (req_r.op == OP_READ) begin
            rsp.result_value <= rd_data;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_WALK: begin
          if (walk_more) begin
            cnt <= cnt + 1'b1;
          end
          pend      <= walk_rd;
          pend_addr <= walk_addr;
          if (walk_end) begin
            rsp.status <= STS_OK;
            if (is_new) begin
              rsp.result_value <= 16'(new_slot);
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_wr_states: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_MOD || state == S_WALK))
    else $error("cell write outside modify or sweep");

  a_no_port_clash: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write to the same cell in one cycle");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.status <= STS_TOO_LARGE))
    else $error("status code out of range");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (cnt <= n_cells))
    else $error("sweep counter ran past the map size");

endmodule

FILE: sv/grid_flag_map_store.sv
// channel   direction  handshake               payload
// request   in         start, busy             req  (gfm_req_t)
// result    out        done (one-cycle strobe) rsp  (gfm_rsp_t)
// config    in         cfg_valid, cfg_ready    cfg_data (flag_mask_limit)
//
// a request is taken when start is high and busy is low; exactly one result follows
// errors found at check, free, free-all, cell-valid and unused codes: done from the check state
// set/clear/test/read: done from the modify state (check, address with cell read, modify)
// allocate, clear/fill map: check, size (too-large ends here), then width*height cells, one cell per cycle
//   through the single write port of the cell memory
// rst clears the slot table; cell memory is not cleared, allocation zeroes its region
// results cannot be held off; cfg_ready is always high; user must write only while idle, not enforced
module grid_flag_map_store #(
  parameter int MAP_SLOTS     = gfm_pkg::MAP_SLOTS_DEF,
  parameter int CELLS_PER_MAP = gfm_pkg::CELLS_PER_MAP_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  gfm_pkg::gfm_req_t          req,
  output logic                       done,
  output gfm_pkg::gfm_rsp_t          rsp,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [gfm_pkg::CELL_W-1:0] cfg_data
);

  import gfm_pkg::*;

  localparam int DEPTH  = MAP_SLOTS * CELLS_PER_MAP;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CELL_W-1:0] flag_mask_limit;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CELL_W-1:0] rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_mask_limit <= FLAG_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      flag_mask_limit <= cfg_data;
    end
  end

  gfm_ctrl #(
    .MAP_SLOTS     (MAP_SLOTS),
    .CELLS_PER_MAP (CELLS_PER_MAP),
    .ADDR_W        (ADDR_W)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .req             (req),
    .flag_mask_limit (flag_mask_limit),
    .done            (done),
    .rsp             (rsp),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data)
  );

  gfm_cell_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (CELL_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
